### hdl/mag_cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer axis calibration package
// Shared widths, register indexes, axis codes and pipeline side data.
// ----------------------------------------------------------------------------
package mag_cal_pkg;

   localparam int RawW   = 24;
   localparam int GainW  = 24;
   localparam int CycW   = 16;
   localparam int DenW   = 32;
   localparam int OffW   = 32;
   localparam int FieldW = 32;
   localparam int SetupW = 42;
   localparam int DivOffW = 64;
   localparam int CurW   = 48;
   localparam int CsrW   = 64;
   localparam int CsrIdxW = 3;
   localparam int MagW   = 2 * GainW;
   localparam int NumW   = 63;
   localparam int DivW   = DenW + CycW;
   localparam int SumW   = NumW + 2;

   typedef enum logic [CsrIdxW-1:0] {
      REG_X_SETUP  = 3'd0,
      REG_X_DIVOFF = 3'd1,
      REG_Y_SETUP  = 3'd2,
      REG_Y_DIVOFF = 3'd3,
      REG_Z_SETUP  = 3'd4,
      REG_Z_DIVOFF = 3'd5,
      REG_CYCLES   = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   localparam logic [SetupW-1:0]  SetupReset  = 42'd1102867070976;
   localparam logic [DivOffW-1:0] DivOffReset = 64'd1;
   localparam logic [CurW-1:0]    CurReset    = 48'd859006566600;

   typedef struct packed {
      logic                   neg;
      logic                   not_cal;
      logic signed [OffW-1:0] offset;
   } side_type;

endpackage

### hdl/mag_cal_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer calibration channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mag_cal_req_if;
   import mag_cal_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             axis_select;
   logic signed [RawW-1:0] raw_counts;
   modport source (output valid, axis_select, raw_counts, input ready);
   modport sink (input valid, axis_select, raw_counts, output ready);
endinterface

interface mag_cal_rsp_if;
   import mag_cal_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [FieldW-1:0] field_picotesla;
   logic                     saturated;
   logic                     not_calibrated;
   modport source (output valid, field_picotesla, saturated, not_calibrated,
                   input ready);
   modport sink (input valid, field_picotesla, saturated, not_calibrated,
                 output ready);
endinterface

### hdl/mag_cal_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned divide, one quotient bit per stage, side data carried along.
// ----------------------------------------------------------------------------
module mag_cal_div
   import mag_cal_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic            in_valid,
   input  logic [NumW-1:0] in_num,
   input  logic [DivW-1:0] in_den,
   input  side_type        in_side,
   output logic            out_valid,
   output logic [NumW-1:0] out_quot,
   output side_type        out_side
);

   logic [DivW-1:0] rem_ff [NumW];
   logic [DivW-1:0] rem_in [NumW];
   logic [NumW-1:0] nq_ff  [NumW];
   logic [NumW-1:0] nq_in  [NumW];
   logic [DivW-1:0] den_ff [NumW];
   side_type        side_ff [NumW];
   logic            vld_ff [NumW];

   always_comb begin
      logic [DivW:0]   trial;
      logic [DivW-1:0] prem;
      logic [NumW-1:0] pnq;
      logic [DivW-1:0] pden;
      for (int k = 0; k < NumW; k++) begin
         if (k == 0) begin
            prem = '0;
            pnq  = in_num;
            pden = in_den;
         end else begin
            prem = rem_ff[k-1];
            pnq  = nq_ff[k-1];
            pden = den_ff[k-1];
         end
         trial = {prem, pnq[NumW-1]};
         if (trial >= {1'b0, pden}) begin
            rem_in[k] = DivW'(trial - {1'b0, pden});
            nq_in[k]  = {pnq[NumW-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[DivW-1:0];
            nq_in[k]  = {pnq[NumW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < NumW; k++) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
            if (k == 0) begin
               den_ff[k]  <= in_den;
               side_ff[k] <= in_side;
            end else begin
               den_ff[k]  <= den_ff[k-1];
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
      if (reset) begin
         for (int k = 0; k < NumW; k++) vld_ff[k] <= 1'b0;
      end else if (enable) begin
         for (int k = 0; k < NumW; k++) begin
            if (k == 0) vld_ff[k] <= in_valid;
            else vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[NumW-1];
   assign out_quot  = nq_ff[NumW-1];
   assign out_side  = side_ff[NumW-1];

endmodule

### hdl/magnetometer_axis_calibration_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer axis calibration
// Scales a raw axis count by the axis gain, divides with rounding, adds the
// offset and saturates to a signed 32-bit picotesla value.
// ----------------------------------------------------------------------------
// The block takes one item per clock while it is not stalled. Each item passes
// operand selection, multiplication and the rounding bias, then the divider,
// which resolves one quotient bit per stage, then offset and saturation. The
// whole pipeline stalls only while a result waits.
module magnetometer_axis_calibration_top
   import mag_cal_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   mag_cal_req_if.sink        req_bus,
   mag_cal_rsp_if.source      rsp_bus,
   input  logic               csr_write_enable,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrW-1:0]    csr_write_data
);

   logic [SetupW-1:0]  setup_ff [3];
   logic [DivOffW-1:0] divoff_ff [3];
   logic [CurW-1:0]    cycles_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            setup_ff[a]  <= SetupReset;
            divoff_ff[a] <= DivOffReset;
         end
         cycles_ff <= CurReset;
      end else if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_X_SETUP:  setup_ff[0]  <= csr_write_data[SetupW-1:0];
            REG_X_DIVOFF: divoff_ff[0] <= csr_write_data;
            REG_Y_SETUP:  setup_ff[1]  <= csr_write_data[SetupW-1:0];
            REG_Y_DIVOFF: divoff_ff[1] <= csr_write_data;
            REG_Z_SETUP:  setup_ff[2]  <= csr_write_data[SetupW-1:0];
            REG_Z_DIVOFF: divoff_ff[2] <= csr_write_data;
            REG_CYCLES:   cycles_ff    <= csr_write_data[CurW-1:0];
            default: ;
         endcase
      end
   end

   logic enable;
   logic out_vld_ff;
   assign enable = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = enable;

   // Stage 1: operand selection.
   logic [SetupW-1:0]  sel_setup;
   logic [DivOffW-1:0] sel_divoff;
   logic [CycW-1:0]    sel_cur;
   logic               sel_bad;
   logic [GainW-1:0]   gain_bits;
   logic [CycW-1:0]    ref_raw;
   logic [CycW-1:0]    ref_in;
   logic [CycW-1:0]    cur_in;
   logic [RawW-1:0]    abs_raw_in;
   logic [GainW-1:0]   abs_gain_in;
   side_type           side1_in;

   always_comb begin
      sel_bad = 1'b0;
      unique case (axis_type'(req_bus.axis_select))
         AXIS_X: begin
            sel_setup = setup_ff[0]; sel_divoff = divoff_ff[0];
            sel_cur = cycles_ff[15:0];
         end
         AXIS_Y: begin
            sel_setup = setup_ff[1]; sel_divoff = divoff_ff[1];
            sel_cur = cycles_ff[31:16];
         end
         AXIS_Z: begin
            sel_setup = setup_ff[2]; sel_divoff = divoff_ff[2];
            sel_cur = cycles_ff[47:32];
         end
         default: begin
            sel_setup = setup_ff[0]; sel_divoff = divoff_ff[0];
            sel_cur = cycles_ff[15:0]; sel_bad = 1'b1;
         end
      endcase
      gain_bits = sel_setup[GainW-1:0];
      ref_raw   = sel_setup[39:24];
      if (sel_setup[40]) begin
         ref_in = (ref_raw == '0) ? sel_cur : ref_raw;
         cur_in = (sel_cur == '0) ? CycW'(1) : sel_cur;
      end else begin
         ref_in = CycW'(1);
         cur_in = CycW'(1);
      end
      abs_raw_in  = req_bus.raw_counts[RawW-1] ? RawW'(-req_bus.raw_counts)
                                               : RawW'(req_bus.raw_counts);
      abs_gain_in = gain_bits[GainW-1] ? GainW'(-gain_bits) : gain_bits;
      side1_in.neg     = req_bus.raw_counts[RawW-1] ^ gain_bits[GainW-1];
      side1_in.not_cal = sel_bad || !sel_setup[41] || (sel_divoff[DenW-1:0] == '0);
      side1_in.offset  = sel_divoff[DivOffW-1:DenW];
   end

   logic             s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [RawW-1:0]  s1_raw_ff;
   logic [GainW-1:0] s1_gain_ff;
   logic [CycW-1:0]  s1_ref_ff, s1_cur_ff, s2_ref_ff;
   logic [DenW-1:0]  s1_den_ff;
   side_type         s1_side_ff, s2_side_ff, s3_side_ff;
   logic [MagW-1:0]  s2_mag_ff;
   logic [DivW-1:0]  s2_den_ff, s3_den_ff;
   logic [NumW-1:0]  s3_mag_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_raw_ff  <= abs_raw_in;
         s1_gain_ff <= abs_gain_in;
         s1_ref_ff  <= ref_in;
         s1_cur_ff  <= cur_in;
         s1_den_ff  <= sel_divoff[DenW-1:0];
         s1_side_ff <= side1_in;
         s2_mag_ff  <= s1_raw_ff * s1_gain_ff;
         s2_den_ff  <= s1_den_ff * s1_cur_ff;
         s2_ref_ff  <= s1_ref_ff;
         s2_side_ff <= s1_side_ff;
         s3_mag_ff  <= NumW'(s2_mag_ff[MagW-2:0]) * NumW'(s2_ref_ff);
         s3_den_ff  <= s2_den_ff;
         s3_side_ff <= s2_side_ff;
      end
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (enable) begin
         s1_vld_ff <= req_bus.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // Stage 4: rounding bias.
   logic            s4_vld_ff;
   logic [NumW-1:0] s4_num_ff;
   logic [DivW-1:0] s4_den_ff;
   side_type        s4_side_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         s4_num_ff  <= s3_mag_ff + NumW'(s3_den_ff >> 1);
         s4_den_ff  <= s3_den_ff;
         s4_side_ff <= s3_side_ff;
      end
      if (reset) s4_vld_ff <= 1'b0;
      else if (enable) s4_vld_ff <= s3_vld_ff;
   end

   logic            dv_vld;
   logic [NumW-1:0] dv_quot;
   side_type        dv_side;

   mag_cal_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (s4_vld_ff),
      .in_num    (s4_num_ff),
      .in_den    (s4_den_ff),
      .in_side   (s4_side_ff),
      .out_valid (dv_vld),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // Stage 5: sign and offset. Stage 6: saturation into the output register.
   logic signed [SumW-1:0] val_in;
   logic signed [SumW-1:0] s5_sum_ff;
   logic                   s5_vld_ff, s5_bad_ff;
   logic signed [FieldW-1:0] field_in;
   logic                     sat_in;
   logic signed [FieldW-1:0] out_field_ff;
   logic                     out_sat_ff, out_bad_ff;

   localparam logic signed [SumW-1:0] MaxVal = SumW'(64'sd2147483647);
   localparam logic signed [SumW-1:0] MinVal = SumW'(-64'sd2147483648);

   always_comb begin
      val_in = dv_side.neg ? -$signed({2'b00, dv_quot}) : $signed({2'b00, dv_quot});
      if (s5_bad_ff) begin
         field_in = '0;
         sat_in   = 1'b0;
      end else if (s5_sum_ff > MaxVal) begin
         field_in = FieldW'(MaxVal);
         sat_in   = 1'b1;
      end else if (s5_sum_ff < MinVal) begin
         field_in = FieldW'(MinVal);
         sat_in   = 1'b1;
      end else begin
         field_in = s5_sum_ff[FieldW-1:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s5_sum_ff    <= val_in + SumW'($signed(dv_side.offset));
         s5_bad_ff    <= dv_side.not_cal;
         out_field_ff <= field_in;
         out_sat_ff   <= sat_in;
         out_bad_ff   <= s5_bad_ff;
      end
      if (reset) begin
         s5_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (enable) begin
         s5_vld_ff  <= dv_vld;
         out_vld_ff <= s5_vld_ff;
      end
   end

   assign rsp_bus.valid           = out_vld_ff;
   assign rsp_bus.field_picotesla = out_field_ff;
   assign rsp_bus.saturated       = out_sat_ff;
   assign rsp_bus.not_calibrated  = out_bad_ff;

   a_uncal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.not_calibrated |->
         rsp_bus.field_picotesla == 0 && !rsp_bus.saturated)
      else $error("uncalibrated item carries a value");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturated |->
         rsp_bus.field_picotesla == 32'sh7FFFFFFF ||
         rsp_bus.field_picotesla == 32'sh80000000)
      else $error("saturated item is not at a range limit");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("item accepted while the pipeline is stalled");

endmodule
